>>> rtl/core/sef_pkg.sv
// Shared types and constants of the Sobel edge filter.
package sef_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int SUM_W      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd64;
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 12'd64;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef logic [PIX_W-1:0] pix_t;

  // Neighbors of one 3x3 window; pRC is row R, column C, top-left is origin.
  typedef struct packed {
    pix_t p00;
    pix_t p01;
    pix_t p02;
    pix_t p10;
    pix_t p12;
    pix_t p20;
    pix_t p21;
    pix_t p22;
  } win_t;

endpackage

>>> rtl/core/sef_line_buf.sv
// Line store memory holding the two previous lines side by side in one word.
module sef_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/sef_kernel.sv
// Sobel gradient sum of one window, clamped to the pixel range.
module sef_kernel (
  input  sef_pkg::win_t win,
  output sef_pkg::pix_t edge_value
);
  import sef_pkg::*;

  logic signed [SUM_W-1:0] gx;
  logic signed [SUM_W-1:0] gy;
  logic signed [SUM_W-1:0] g;

  function automatic logic signed [SUM_W-1:0] ext(input pix_t p);
    ext = $signed({{(SUM_W-PIX_W){1'b0}}, p});
  endfunction

  always_comb begin
    gx = ext(win.p02) - ext(win.p00) + ((ext(win.p12) - ext(win.p10)) <<< 1)
       + ext(win.p22) - ext(win.p20);
    gy = ext(win.p00) + ext(win.p02) + ((ext(win.p01) - ext(win.p21)) <<< 1)
       - ext(win.p20) - ext(win.p22);
    g  = gx + gy;
    if (g < 0) begin
      edge_value = '0;
    end else if (g > ext(PIX_MAX)) begin
      edge_value = PIX_MAX;
    end else begin
      edge_value = g[PIX_W-1:0];
    end
  end

endmodule

>>> rtl/core/sobel_edge_filter.sv
// Top level of the streaming 3x3 Sobel edge filter.
//
//   channel | direction | payload                      | handshake
//   in      | input     | in_pixel                     | in_valid / in_ready
//   out     | output    | out_edge_value, out_frame_last | out_valid / out_ready
//   cfg     | input     | cfg_index, cfg_data          | cfg_valid / cfg_ready
//
// One pixel word is taken per clock unless the input stage stalls; each word waits in
// the input stage while the line store read completes, and its result word enters the
// output register when that stage advances. Border pixels give no result word.
// Reset is synchronous and active low; line store contents are not cleared.
// A held output word stalls the input stage only when that stage carries a result.
// Configuration writes are taken at every clock; cfg_ready stays high.
module sobel_edge_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sef_pkg::PIX_W-1:0]           in_pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sef_pkg::PIX_W-1:0]           out_edge_value,
  output logic                                out_frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sef_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sef_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sef_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WX = (CW + 2 > FW_W + 1) ? CW + 2 : FW_W + 1;

  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic [CW-1:0]    col_cnt_r;
  logic [FH_W-1:0]  row_cnt_r;
  logic [CW-1:0]    last_col;
  logic [FH_W-1:0]  last_row;
  logic [WX-1:0]    w_ext;
  logic             col_end;
  logic             row_end;
  logic [CW-1:0]    idx;
  logic             accept;

  logic             v1_r;
  pix_t             pix_r;
  logic [CW-1:0]    idx_r;
  logic             emit_r;
  logic             last_r;
  logic             adv1;

  pix_t             wc_r [6];
  logic [2*PIX_W-1:0] rd_data;
  pix_t             top;
  pix_t             mid;
  win_t             win;
  pix_t             edge_value;

  logic             out_valid_r;
  pix_t             out_edge_value_r;
  logic             out_frame_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext = WX'(frame_width_r);
    if (w_ext < WX'(3)) begin
      last_col = CW'(2);
    end else if (w_ext > WX'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(w_ext - WX'(1));
    end
    if (frame_height_r < FH_W'(3)) begin
      last_row = FH_W'(2);
    end else begin
      last_row = frame_height_r - FH_W'(1);
    end
  end

  assign col_end = (col_cnt_r >= last_col);
  assign row_end = (row_cnt_r >= last_row);
  assign idx     = col_end ? last_col : col_cnt_r;

  assign adv1     = v1_r && (!emit_r || !out_valid_r || out_ready);
  assign in_ready = !v1_r || adv1;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_cnt_r <= '0;
        row_cnt_r <= row_end ? '0 : row_cnt_r + FH_W'(1);
      end else begin
        col_cnt_r <= col_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (accept) begin
      v1_r <= 1'b1;
    end else if (adv1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r  <= in_pixel;
      idx_r  <= idx;
      emit_r <= (row_cnt_r >= FH_W'(2)) && (col_cnt_r >= CW'(2));
      last_r <= col_end && row_end;
    end
  end

  // Upper byte is the line two above, lower byte the line just above.
  sef_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (2 * PIX_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (rd_data),
    .wr_en   (adv1),
    .wr_addr (idx_r),
    .wr_data ({mid, pix_r})
  );

  assign top = rd_data[2*PIX_W-1:PIX_W];
  assign mid = rd_data[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        wc_r[i] <= '0;
      end
    end else if (adv1) begin
      wc_r[0] <= wc_r[3];
      wc_r[1] <= wc_r[4];
      wc_r[2] <= wc_r[5];
      wc_r[3] <= top;
      wc_r[4] <= mid;
      wc_r[5] <= pix_r;
    end
  end

  always_comb begin
    win.p00 = wc_r[0];
    win.p10 = wc_r[1];
    win.p20 = wc_r[2];
    win.p01 = wc_r[3];
    win.p21 = wc_r[5];
    win.p02 = top;
    win.p12 = mid;
    win.p22 = pix_r;
  end

  sef_kernel u_kernel (
    .win        (win),
    .edge_value (edge_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv1 && emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && emit_r) begin
      out_edge_value_r <= edge_value;
      out_frame_last_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_value = out_edge_value_r;
  assign out_frame_last = out_frame_last_r;

endmodule

>>> rtl/core/sef_checker.sv
// Port-level assertions of the Sobel edge filter and their binding.
module sef_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sef_pkg::PIX_W-1:0]       out_edge_value,
  input logic                            out_frame_last,
  input logic                            cfg_ready
);

  // A result word that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_edge_value)
      && $stable(out_frame_last))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // With the output register empty nothing can hold back the input stage.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration write refused");

endmodule

bind sobel_edge_filter sef_checker u_sef_checker (.*);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench of the Sobel edge filter: pixel stimulus, edge prediction per accepted pixel, checks.
module tb_top;
  import sef_pkg::*;

  localparam int MAX_W = 1024;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PIXELS = 640;

  typedef struct packed {
    pix_t edge_value;
    logic frame_last;
  } edge_word_t;

  typedef enum int {FILL_RANDOM, FILL_SMOOTH, FILL_BINARY} fill_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_t in_pixel = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_t out_edge_value;
  logic out_frame_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pix_t pixel_backlog[$];
  edge_word_t expected_edges[$];
  edge_word_t head_edge;

  pix_t upper_line[MAX_W];
  pix_t second_line[MAX_W];
  pix_t window_cols[6];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;

  bit steady;
  bit pixel_taken;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned pixels_pushed;
  int unsigned pixels_taken;
  int unsigned edges_seen;
  int unsigned frame_ends;
  int unsigned reg_writes;
  int unsigned errors;

  sobel_edge_filter #(.MAX_WIDTH(MAX_W)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pixel(in_pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_edge_value(out_edge_value),
    .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (steady || roll < 60) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic int unsigned active_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function automatic int unsigned pixels_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned n;
    w = active_width();
    h = active_height();
    n = (col_pos >= w - 1) ? 1 : w - col_pos;
    if (row_pos < h - 1) n += (h - 1 - row_pos) * w;
    return n;
  endfunction

  function automatic void predict_edge(pix_t p);
    int unsigned w;
    int unsigned h;
    int unsigned slot;
    int top, mid, p00, p01, p10, p20, p21, p22, gx, gy, g;
    bit col_end;
    bit row_end;
    edge_word_t word;
    w = active_width();
    h = active_height();
    slot = (col_pos < w) ? col_pos : w - 1;
    top = second_line[slot];
    mid = upper_line[slot];
    col_end = (col_pos >= w - 1);
    row_end = (row_pos >= h - 1);
    second_line[slot] = pix_t'(mid);
    upper_line[slot] = p;
    if (row_pos >= 2 && col_pos >= 2) begin
      p00 = window_cols[0];
      p10 = window_cols[1];
      p20 = window_cols[2];
      p01 = window_cols[3];
      p21 = window_cols[5];
      p22 = p;
      gx = -p00 + top - 2 * p10 + 2 * mid - p20 + p22;
      gy = p00 + 2 * p01 + top - p20 - 2 * p21 - p22;
      g = gx + gy;
      if (g < 0) g = 0;
      if (g > int'(PIX_MAX)) g = int'(PIX_MAX);
      word.edge_value = pix_t'(g);
      word.frame_last = col_end && row_end;
      expected_edges.push_back(word);
    end
    window_cols[0] = window_cols[3];
    window_cols[1] = window_cols[4];
    window_cols[2] = window_cols[5];
    window_cols[3] = pix_t'(top);
    window_cols[4] = pix_t'(mid);
    window_cols[5] = p;
    if (col_end) begin
      col_pos = 0;
      row_pos = row_end ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic void push_pixels(int unsigned n, fill_kind_t kind);
    pix_t base;
    base = pix_t'($urandom_range(255));
    repeat (n) begin
      case (kind)
        FILL_SMOOTH: pixel_backlog.push_back(pix_t'(base + $urandom_range(12)));
        FILL_BINARY: pixel_backlog.push_back($urandom_range(1) ? PIX_MAX : pix_t'(0));
        default: pixel_backlog.push_back(pix_t'($urandom_range(255)));
      endcase
    end
    pixels_pushed += n;
  endfunction

  task automatic settle();
    do @(negedge clk); while (pixels_taken != pixels_pushed || expected_edges.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(bit set_w, logic [CFG_DATA_W-1:0] w, bit set_h,
                           logic [CFG_DATA_W-1:0] h);
    settle();
    if (set_w) write_reg(REG_FRAME_WIDTH, w);
    if (set_h) write_reg(REG_FRAME_HEIGHT, h);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !pixel_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap != 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pixel_backlog.size() != 0) begin
      in_valid <= 1'b1;
      in_pixel <= pixel_backlog.pop_front();
      send_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_taken <= 1'b0;
    end else begin
      pixel_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        edges_seen++;
        if (out_frame_last) frame_ends++;
        if (expected_edges.size() == 0) begin
          errors++;
          $error("unexpected edge word: edge_value %0d, frame_last %0b",
                 out_edge_value, out_frame_last);
        end else begin
          head_edge = expected_edges.pop_front();
          if (out_edge_value !== head_edge.edge_value) begin
            errors++;
            $error("edge_value: expected %0d, actual %0d", head_edge.edge_value, out_edge_value);
          end
          if (out_frame_last !== head_edge.frame_last) begin
            errors++;
            $error("frame_last: expected %0b, actual %0b", head_edge.frame_last, out_frame_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          REG_FRAME_WIDTH: width_reg = cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data[FH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pixels_taken++;
        predict_edge(in_pixel);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned n;
    int unsigned roll;
    bit set_w;
    bit set_h;
    logic [FW_W-1:0] w_val;
    logic [FH_W-1:0] h_val;
    fill_kind_t kind;
    pix_t corner_frames[27];
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      second_line[i] = '0;
    end
    foreach (window_cols[i]) window_cols[i] = '0;
    col_pos = 0;
    row_pos = 0;
    width_reg = RST_FRAME_WIDTH;
    height_reg = RST_FRAME_HEIGHT;
    random_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset sizes first; the height is then cut below the row in progress.
    push_pixels(64 * 4 + 10, FILL_RANDOM);
    configure(1'b0, '0, 1'b1, '0);
    push_pixels(pixels_to_frame_end(), FILL_SMOOTH);

    // Three 3x3 frames: positive saturation, negative clamp and an unclamped sum.
    corner_frames = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
                      8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0,
                      8'd0, 8'd0, 8'd30, 8'd0, 8'd0, 8'd50, 8'd0, 8'd0, 8'd0};
    configure(1'b1, '0, 1'b0, '0);
    foreach (corner_frames[i]) pixel_backlog.push_back(corner_frames[i]);
    pixels_pushed += 27;

    // The width shrinks below the current column in the middle of a frame.
    configure(1'b1, 12'd10, 1'b1, 12'd6);
    push_pixels(3 * 10 + 5, FILL_RANDOM);
    configure(1'b1, 12'd4, 1'b0, '0);
    push_pixels(pixels_to_frame_end(), FILL_BINARY);

    configure(1'b1, 12'd2047, 1'b1, 12'd3);
    push_pixels(40, FILL_RANDOM);
    configure(1'b1, 12'd6, 1'b0, '0);
    push_pixels(pixels_to_frame_end(), FILL_RANDOM);
    configure(1'b1, 12'd1024, 1'b1, 12'd1);
    push_pixels(40, FILL_SMOOTH);
    configure(1'b1, 12'd5, 1'b0, '0);
    push_pixels(pixels_to_frame_end(), FILL_SMOOTH);
    configure(1'b1, 12'd3, 1'b1, 12'd4095);
    push_pixels(3 * 40, FILL_RANDOM);
    configure(1'b0, '0, 1'b1, 12'd6);
    push_pixels(pixels_to_frame_end(), FILL_RANDOM);

    while (random_sent < RANDOM_PIXELS) begin
      set_w = ($urandom_range(2) != 0);
      set_h = ($urandom_range(2) != 0);
      roll = $urandom_range(99);
      if (roll < 10) w_val = FW_W'($urandom_range(2));
      else if (roll < 80) w_val = FW_W'($urandom_range(12, 3));
      else w_val = FW_W'($urandom_range(40, 13));
      roll = $urandom_range(99);
      if (roll < 10) h_val = FH_W'($urandom_range(2));
      else if (roll < 85) h_val = FH_W'($urandom_range(8, 3));
      else h_val = FH_W'($urandom_range(20, 9));
      configure(set_w, {1'($urandom_range(1)), w_val}, set_h, h_val);
      steady = ($urandom_range(4) == 0);
      kind = fill_kind_t'($urandom_range(2));
      n = pixels_to_frame_end();
      if ($urandom_range(99) < 70) n += $urandom_range(1) * active_width() * active_height();
      else n = $urandom_range(n, 1);
      if (n > RANDOM_PIXELS - random_sent) n = RANDOM_PIXELS - random_sent;
      push_pixels(n, kind);
      random_sent += n;
    end

    settle();
    $display("Streamed %0d pixels across %0d register writes, with sizes changed mid-frame",
             pixels_taken, reg_writes);
    $display("and clamped at both ends; %0d edge words checked, %0d of them closing a frame.",
             edges_seen, frame_ends);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
